// File: rtl/core/qpe_pkg.sv
// Package: shared types, constants and helpers for the quoted-printable encoder.
`timescale 1ns / 1ps
`default_nettype none

package qpe_pkg;

    typedef logic [7:0] byte_t;

    localparam int RUN_MAX = 5;
    localparam int CNT_W   = $clog2(RUN_MAX + 1);

    typedef logic [CNT_W-1:0] cnt_t;

    localparam byte_t CHAR_EQ          = 8'h3D;
    localparam byte_t CHAR_LF          = 8'h0A;
    localparam byte_t PRINT_LO         = 8'd32;
    localparam byte_t PRINT_HI         = 8'd128;
    localparam byte_t LINE_LIMIT_RESET = 8'd75;

    // Uppercase hex digit for one nibble.
    function automatic byte_t hex_char(input logic [3:0] nib);
        byte_t c;
        if (nib < 4'd10)
        begin
            c = 8'h30 + {4'h0, nib};
        end
        else
        begin
            c = 8'h37 + {4'h0, nib};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/qpe_if.sv
// Interfaces: raw byte input, encoded character output and line limit write channel.
`timescale 1ns / 1ps
`default_nettype none

interface qpe_in_if;
    logic                valid;
    logic                ready;
    qpe_pkg::byte_t      in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface qpe_out_if;
    logic                valid;
    logic                ready;
    qpe_pkg::byte_t      out_byte;
    logic                last_of_run;
    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface qpe_cfg_if;
    logic                valid;
    logic                ready;
    qpe_pkg::byte_t      line_limit;
    modport source (output valid, output line_limit, input ready);
    modport sink   (input valid, input line_limit, output ready);
endinterface

`default_nettype wire

// File: rtl/core/quoted_printable_encoder_top.sv
// Top level: quoted-printable encoder with column tracking and soft line breaks.
//
//  channel | dir | payload                  | word
//  --------+-----+--------------------------+-------------------------------
//  raw     | in  | in_byte                  | one raw byte
//  enc     | out | out_byte, last_of_run    | one encoded character
//  cfg     | in  | line_limit               | line limit write, always ready
//
//  A byte yields 1 to 5 characters, one per cycle on enc while enc is ready;
//  the output port's one character per cycle sets the rate.
//  A byte is held in an input register, then encoded in one step into a run
//  buffer; the next byte is taken while the run drains.
//  Reset clears the column and all valid state and sets the line limit to 75.
//  Stalls on enc hold the run; raw backs up while the input register is full and cannot load.
`timescale 1ns / 1ps
`default_nettype none

module quoted_printable_encoder_top
(
    input  wire logic clk,
    input  wire logic rst_n,
    qpe_in_if.sink    raw,
    qpe_out_if.source enc,
    qpe_cfg_if.sink   cfg
);
    import qpe_pkg::*;

    logic   hold_valid_reg;
    byte_t  hold_byte_reg;
    byte_t  line_limit_reg;
    byte_t  column_reg;
    byte_t  column_next;
    byte_t  run_chars_reg [RUN_MAX];
    byte_t  run_chars_next [RUN_MAX];
    cnt_t   run_cnt_reg;
    cnt_t   run_cnt_next;
    logic   out_fire;
    logic   raw_fire;
    logic   load;
    logic   printable;
    logic   brk;
    logic [8:0] col_ext;
    logic [8:0] col_inc;
    logic [8:0] col_add3;
    logic [8:0] lim_ext;

    assign out_fire = enc.valid && enc.ready;
    assign load     = hold_valid_reg &&
                      ((run_cnt_reg == '0) || (run_cnt_reg == cnt_t'(1) && enc.ready));
    assign raw.ready = !hold_valid_reg || load;
    assign raw_fire  = raw.valid && raw.ready;
    assign cfg.ready = 1'b1;

    assign enc.valid       = (run_cnt_reg != '0);
    assign enc.out_byte    = run_chars_reg[0];
    assign enc.last_of_run = (run_cnt_reg == cnt_t'(1));

    // Encode step
    assign col_ext  = {1'b0, column_reg};
    assign lim_ext  = {1'b0, line_limit_reg};
    assign col_inc  = col_ext + 9'd1;
    assign col_add3 = col_ext + 9'd3;
    assign printable = (hold_byte_reg >= PRINT_LO) && (hold_byte_reg < PRINT_HI) &&
                       (hold_byte_reg != CHAR_EQ);

    always_comb
    begin
        for (int i = 0; i < RUN_MAX; i++)
        begin
            run_chars_next[i] = CHAR_EQ;
        end
        run_cnt_next = '0;
        column_next  = column_reg;
        brk          = 1'b0;
        if (printable)
        begin
            brk = (col_inc > lim_ext);
            if (brk)
            begin
                column_next       = '0;
                run_chars_next[0] = CHAR_EQ;
                run_chars_next[1] = CHAR_LF;
                run_chars_next[2] = hold_byte_reg;
                run_cnt_next      = cnt_t'(3);
            end
            else
            begin
                column_next       = col_inc[8] ? 8'hFF : col_inc[7:0];
                run_chars_next[0] = hold_byte_reg;
                run_cnt_next      = cnt_t'(1);
            end
        end
        else if (hold_byte_reg == CHAR_LF)
        begin
            column_next       = '0;
            run_chars_next[0] = CHAR_LF;
            run_cnt_next      = cnt_t'(1);
        end
        else
        begin
            brk = ((col_ext + 9'd2) > lim_ext);
            if (brk)
            begin
                column_next       = 8'd3;
                run_chars_next[0] = CHAR_EQ;
                run_chars_next[1] = CHAR_LF;
                run_chars_next[2] = CHAR_EQ;
                run_chars_next[3] = hex_char(hold_byte_reg[7:4]);
                run_chars_next[4] = hex_char(hold_byte_reg[3:0]);
                run_cnt_next      = cnt_t'(5);
            end
            else
            begin
                column_next       = col_add3[8] ? 8'hFF : col_add3[7:0];
                run_chars_next[0] = CHAR_EQ;
                run_chars_next[1] = hex_char(hold_byte_reg[7:4]);
                run_chars_next[2] = hex_char(hold_byte_reg[3:0]);
                run_cnt_next      = cnt_t'(3);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            run_cnt_reg    <= '0;
            column_reg     <= '0;
            line_limit_reg <= LINE_LIMIT_RESET;
        end
        else
        begin
            if (cfg.valid)
            begin
                line_limit_reg <= cfg.line_limit;
            end
            if (raw_fire)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (load)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (load)
            begin
                run_cnt_reg <= run_cnt_next;
                column_reg  <= column_next;
            end
            else if (out_fire)
            begin
                run_cnt_reg <= run_cnt_reg - cnt_t'(1);
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (raw_fire)
        begin
            hold_byte_reg <= raw.in_byte;
        end
        if (load)
        begin
            for (int i = 0; i < RUN_MAX; i++)
            begin
                run_chars_reg[i] <= run_chars_next[i];
            end
        end
        else if (out_fire)
        begin
            for (int i = 0; i < RUN_MAX - 1; i++)
            begin
                run_chars_reg[i] <= run_chars_reg[i + 1];
            end
        end
    end

    a_run_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        run_cnt_reg <= cnt_t'(RUN_MAX))
        else $error("run count above maximum");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (run_cnt_reg == '0) || (run_cnt_reg == cnt_t'(1) && out_fire))
        else $error("run reloaded while characters remain");

    a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> run_cnt_reg != '0)
        else $error("load produced an empty run");

    a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg && !load |=> hold_valid_reg && $stable(hold_byte_reg))
        else $error("held byte lost before encoding");

endmodule

`default_nettype wire
